>>> sv/xmcr_pkg.sv
package xmcr_pkg;

	localparam int MAX_PACKET_DEF = 1024;

	localparam logic [7:0] CH_SOH  = 8'h01;
	localparam logic [7:0] CH_STX  = 8'h02;
	localparam logic [7:0] CH_EOT  = 8'h04;
	localparam logic [7:0] CH_ACK  = 8'h06;
	localparam logic [7:0] CH_NAK  = 8'h15;
	localparam logic [7:0] CH_CAN  = 8'h18;
	localparam logic [7:0] CH_POLL = 8'h43;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_TMO   = 2'd2;
	localparam logic [1:0] ACT_STORE = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_TIMEOUT = 3'd1;
	localparam logic [2:0] ST_CANCEL  = 3'd2;
	localparam logic [2:0] ST_SYNC    = 3'd3;
	localparam logic [2:0] ST_RETRY   = 3'd4;
	localparam logic [2:0] ST_STORE   = 3'd5;

	localparam int CFG_LONG_SIZE = 0;
	localparam int CFG_RETRIES   = 1;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  rx_byte;
		logic        store_failed;
	} in_item_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic [9:0]  data_index;
		logic        packet_ready;
		logic [10:0] packet_length;
		logic        done_res;
		logic [2:0]  status;
		logic        last;
	} res_t;

	// compact job handed from the engine to the result expander
	typedef struct packed {
		logic [2:0]  n;        // number of results, 1..4
		logic [1:0]  kind;
		logic [7:0]  b0;       // first byte to send or data byte
		logic [9:0]  idx;
		logic [10:0] plen;
		logic        poll;     // a poll 'C' is sent, alone or trailing an ACK/NAK
		logic [2:0]  status;
	} job_t;

	localparam logic [1:0] K_SEND  = 2'd0; // n sends: b0 once or thrice (CAN triple), or b0 then a poll or three CANs
	localparam logic [1:0] K_DATA  = 2'd1;
	localparam logic [1:0] K_READY = 2'd2;
	localparam logic [1:0] K_TMO   = 2'd3;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		return c;
	endfunction

endpackage

>>> sv/xmcr_if.sv
interface xmcr_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/xmcr_engine.sv
module xmcr_engine import xmcr_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);
	localparam logic [3:0] PH_IDLE = 4'd0, PH_SYNC = 4'd1, PH_CANWAIT = 4'd2,
		PH_BLKNO = 4'd3, PH_BLKCMP = 4'd4, PH_DATA = 4'd5, PH_CRCHI = 4'd6,
		PH_CRCLO = 4'd7, PH_CRCLO_BAD = 4'd8, PH_FLUSH = 4'd9, PH_STORE = 4'd10;
	localparam logic [10:0] MAXP = 11'(MAX_PACKET);

	logic [10:0] long_q;
	logic [3:0]  retries_q;
	logic [3:0]  phase_q, phase_d;
	logic [4:0]  retry_q, retry_d;
	logic [7:0]  exp_q, exp_d, rblk_q, rblk_d;
	logic [10:0] psize_q, psize_d, cnt_q, cnt_d;
	logic [15:0] crc_q, crc_d;
	logic        emit;
	job_t        j;
	logic        take;

	// a job slot: the output queue absorbs it, so stall only when it is full
	assign in_ready = !job_valid || job_ready;
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q <= 11'd250;
			retries_q <= 4'd10;
		end else if (cfg_we) begin
			if (cfg_index == 1'(CFG_LONG_SIZE)) long_q <= cfg_data;
			else retries_q <= cfg_data[3:0];
		end
	end

	always_comb begin
		logic [10:0] ls;
		logic [5:0]  lim;
		logic [4:0]  rc;
		logic        c;
		logic [7:0]  b;
		phase_d = phase_q; retry_d = retry_q; exp_d = exp_q; rblk_d = rblk_q;
		psize_d = psize_q; cnt_d = cnt_q; crc_d = crc_q;
		emit = 1'b0;
		j = '0;
		b = in_item.rx_byte;
		ls = (long_q < 11'd128) ? 11'd128 : ((long_q > MAXP) ? MAXP : long_q);
		c = 1'b0; // request poll step
		rc = retry_q;
		lim = '0;
		case (in_item.action)
			ACT_START: begin
				rc = '0; exp_d = 8'd1; rblk_d = '0; psize_d = '0; cnt_d = '0; crc_d = '0;
				c = 1'b1;
			end
			ACT_STORE: begin
				if (phase_q == PH_STORE) begin
					if (in_item.store_failed) begin
						emit = 1'b1; j.n = 3'd3; j.b0 = CH_CAN; j.status = ST_STORE;
						phase_d = PH_IDLE;
					end else begin
						if (rblk_q == exp_q) exp_d = exp_q + 8'd1;
						emit = 1'b1; j.n = 3'd1; j.b0 = CH_ACK;
						rc = '0; c = 1'b1;
					end
				end
			end
			default: begin
				case (phase_q)
					PH_SYNC: begin
						if (in_item.action != ACT_BYTE) c = 1'b1;
						else if (b == CH_SOH || b == CH_STX) begin
							psize_d = (b == CH_SOH) ? 11'd128 : ls;
							phase_d = PH_BLKNO;
						end else if (b == CH_EOT) begin
							emit = 1'b1; j.n = 3'd1; j.b0 = CH_ACK; j.status = ST_OK;
							j.kind = K_SEND; j.plen = 11'd1; phase_d = PH_IDLE;
						end else if (b == CH_CAN) phase_d = PH_CANWAIT;
						else c = 1'b1;
					end
					PH_CANWAIT: begin
						if (in_item.action == ACT_BYTE && b == CH_CAN) begin
							emit = 1'b1; j.n = 3'd1; j.b0 = CH_ACK; j.status = ST_CANCEL;
							j.plen = 11'd1; phase_d = PH_IDLE;
						end else c = 1'b1;
					end
					PH_IDLE, PH_STORE: ;
					PH_FLUSH: begin
						cnt_d = cnt_q + 11'd1;
						if ({1'b0, cnt_d} >= {1'b0, psize_q} + 12'd2) begin
							rc = retry_q + 5'd1;
							if ({1'b0, rc} > {2'b0, retries_q}) begin
								emit = 1'b1; j.n = 3'd3; j.b0 = CH_CAN; j.status = ST_RETRY;
								phase_d = PH_IDLE;
							end else begin
								emit = 1'b1; j.n = 3'd1; j.b0 = CH_NAK; c = 1'b1;
							end
						end
					end
					default: begin
						if (in_item.action != ACT_BYTE) begin
							emit = 1'b1; j.n = 3'd1; j.kind = K_TMO; j.status = ST_TIMEOUT;
							phase_d = PH_IDLE;
						end else begin
							case (phase_q)
								PH_BLKNO: begin rblk_d = b; phase_d = PH_BLKCMP; end
								PH_BLKCMP: begin
									cnt_d = '0; crc_d = '0;
									if (rblk_q != ~b || (rblk_q != exp_q && rblk_q != exp_q - 8'd1))
										phase_d = PH_FLUSH;
									else phase_d = PH_DATA;
								end
								PH_DATA: begin
									crc_d = crc_byte(crc_q, b);
									emit = 1'b1; j.n = 3'd1; j.kind = K_DATA; j.b0 = b;
									j.idx = cnt_q[9:0];
									cnt_d = cnt_q + 11'd1;
									if (cnt_d >= psize_q) phase_d = PH_CRCHI;
								end
								PH_CRCHI: phase_d = (b == crc_q[15:8]) ? PH_CRCLO : PH_CRCLO_BAD;
								default: begin
									if (phase_q == PH_CRCLO && b == crc_q[7:0]) begin
										emit = 1'b1; j.n = 3'd1; j.kind = K_READY;
										j.plen = psize_q; phase_d = PH_STORE;
									end else begin
										rc = retry_q + 5'd1;
										if ({1'b0, rc} > {2'b0, retries_q}) begin
											emit = 1'b1; j.n = 3'd3; j.b0 = CH_CAN;
											j.status = ST_RETRY; phase_d = PH_IDLE;
										end else begin
											emit = 1'b1; j.n = 3'd1; j.b0 = CH_NAK; c = 1'b1;
										end
									end
								end
							endcase
						end
					end
				endcase
			end
		endcase
		// poll step, possibly after an ACK or NAK already queued (j.n = 1)
		if (c) begin
			lim = (psize_d == '0) ? {1'b0, retries_q, 1'b0} : {2'b0, retries_q};
			rc = rc + 5'd1;
			if ({1'b0, rc} > lim) begin
				j.n = emit ? 3'd4 : 3'd3;
				j.poll = 1'b0; j.status = ST_SYNC; j.plen = 11'd1;
				if (!emit) j.b0 = CH_CAN;
				j.kind = K_SEND; emit = 1'b1; phase_d = PH_IDLE;
			end else begin
				phase_d = PH_SYNC;
				if (psize_d == '0) begin
					j.poll = 1'b1;
					if (emit) j.n = 3'd2;
					else begin j.n = 3'd1; j.b0 = CH_POLL; end
					emit = 1'b1;
				end
			end
		end
		// plen on send jobs flags that the final result ends the session
		if (j.kind == K_SEND && (j.n == 3'd3 && j.b0 == CH_CAN)) j.plen = 11'd1;
		retry_d = rc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; retry_q <= '0; exp_q <= 8'd1; rblk_q <= '0;
			psize_q <= '0; cnt_q <= '0; crc_q <= '0; job_valid <= 1'b0;
		end else begin
			if (take && emit) job_valid <= 1'b1;
			else if (job_ready) job_valid <= 1'b0;
			if (take) begin
				phase_q <= phase_d; retry_q <= retry_d; exp_q <= exp_d;
				rblk_q <= rblk_d; psize_q <= psize_d; cnt_q <= cnt_d; crc_q <= crc_d;
			end
		end
	end

	always_ff @(posedge clk) if (take && emit) job <= j;
endmodule

>>> sv/xmcr_expander.sv
module xmcr_expander import xmcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);
	logic [1:0] pos_q;
	logic       fin;

	assign res_valid = job_valid;
	assign fin = ({1'b0, pos_q} == job.n - 3'd1);
	assign job_ready = res_valid && res_ready && fin;

	always_comb begin
		res = '0;
		res.last = fin;
		case (job.kind)
			K_DATA: begin
				res.data_valid = 1'b1; res.data_byte = job.b0; res.data_index = job.idx;
			end
			K_READY: begin res.packet_ready = 1'b1; res.packet_length = job.plen; end
			K_TMO: begin res.done_res = 1'b1; res.status = job.status; end
			default: begin
				res.send_valid = 1'b1;
				// four: ack/nak then three cans; two: ack/nak then poll
				if (job.n == 3'd4) res.send_byte = (pos_q == 2'd0) ? job.b0 : CH_CAN;
				else if (job.n == 3'd2) res.send_byte = (pos_q == 2'd0) ? job.b0 : CH_POLL;
				else res.send_byte = job.b0;
				if (fin && job.plen[0]) begin
					res.done_res = 1'b1; res.status = job.status;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pos_q <= '0;
		else if (res_valid && res_ready) pos_q <= fin ? 2'd0 : pos_q + 2'd1;
	end
endmodule

>>> sv/xmodem_crc_receiver_unit.sv
// XMODEM-CRC receiver. Each accepted item (start, byte, timeout, store result) is
// classified combinationally by the engine, so items can be taken back to back; its
// one to four results then come out one per cycle while the output is ready, from a
// single-entry job queue, starting the cycle after the transfer. The input is held
// until the last result of the previous item is taken.
// The engine updates its state, with byte-wise CRC, once per accepted item.
module xmodem_crc_receiver_unit import xmcr_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	xmcr_if.sink        in_ch,
	xmcr_if.source      out_ch
);
	logic job_valid, job_ready;
	job_t job;
	res_t res;

	xmcr_engine #(.MAX_PACKET(MAX_PACKET)) u_eng (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
		.job_valid, .job_ready, .job
	);

	xmcr_expander u_exp (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
	);

	assign out_ch.payload = res;
endmodule

>>> sv/xmcr_checker.sv
module xmcr_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [44:0] out_payload
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload)) else $error("hold");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({out_payload[44], out_payload[35], out_payload[16],
			out_payload[4] && !out_payload[44]}) <= 1) else $error("mix");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("stall");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload[4] |-> out_payload[0]) else $error("done");
endmodule

bind xmodem_crc_receiver_unit xmcr_props u_chk (
	.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);

>>> tb/sv/xmcr_checker.sv
module xmcr_checker import xmcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [10:0] in_payload,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [44:0] out_payload,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		P_IDLE, P_SYNC, P_CANWAIT, P_BLKNO, P_BLKCMP, P_DATA,
		P_CRCHI, P_CRCLO, P_CRCLO_BAD, P_FLUSH, P_STORE
	} rx_phase_t;

	logic [10:0] long_size_reg;
	logic [3:0]  retry_limit;
	rx_phase_t   phase;
	logic [4:0]  retries;
	logic [7:0]  exp_blk;
	logic [7:0]  rcv_blk;
	logic [10:0] pkt_size;
	logic [10:0] byte_cnt;
	logic [15:0] crc;

	res_t expected_results[$];
	res_t step_res[$];

	assign pending = expected_results.size();

	task automatic push_res(input logic sv, input logic [7:0] sb, input logic dv,
			input logic [7:0] db, input logic [9:0] di, input logic pr,
			input logic [10:0] pl, input logic dn, input logic [2:0] st);
		res_t r;
		r = '0;
		r.send_valid = sv; r.send_byte = sb; r.data_valid = dv; r.data_byte = db;
		r.data_index = di; r.packet_ready = pr; r.packet_length = pl;
		r.done_res = dn; r.status = st;
		step_res.push_back(r);
	endtask

	task automatic send_char(input logic [7:0] b);
		push_res(1, b, 0, 0, 0, 0, 0, 0, ST_OK);
	endtask

	task automatic end_with(input logic [7:0] b, input logic [2:0] st);
		push_res(1, b, 0, 0, 0, 0, 0, 1, st);
		phase = P_IDLE;
	endtask

	task automatic cancel_session(input logic [2:0] st);
		send_char(CH_CAN);
		send_char(CH_CAN);
		end_with(CH_CAN, st);
	endtask

	task automatic rx_timeout();
		push_res(0, 0, 0, 0, 0, 0, 0, 1, ST_TIMEOUT);
		phase = P_IDLE;
	endtask

	task automatic poll();
		int lim;
		lim = (pkt_size == 0) ? 2 * retry_limit : retry_limit;
		retries = retries + 1;
		if (retries > lim) begin
			cancel_session(ST_SYNC);
			return;
		end
		if (pkt_size == 0)
			send_char(CH_POLL);
		phase = P_SYNC;
	endtask

	task automatic nak_or_give_up();
		retries = retries + 1;
		if (retries > retry_limit) begin
			cancel_session(ST_RETRY);
			return;
		end
		send_char(CH_NAK);
		poll();
	endtask

	function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
		return v;
	endfunction

	task automatic predict_item(input in_item_t it);
		logic is_byte;
		logic [7:0] c;
		is_byte = (it.action == ACT_BYTE);
		c = it.rx_byte;
		step_res.delete();
		if (it.action == ACT_START) begin
			retries = 0; exp_blk = 1; rcv_blk = 0; pkt_size = 0; byte_cnt = 0; crc = 0;
			poll();
		end else if (it.action == ACT_STORE) begin
			if (phase == P_STORE) begin
				if (it.store_failed)
					cancel_session(ST_STORE);
				else begin
					if (rcv_blk == exp_blk)
						exp_blk = exp_blk + 1;
					send_char(CH_ACK);
					retries = 0;
					poll();
				end
			end
		end else begin
			case (phase)
				P_SYNC: begin
					if (!is_byte)
						poll();
					else if (c == CH_SOH || c == CH_STX) begin
						if (c == CH_SOH)
							pkt_size = 128;
						else if (long_size_reg < 128)
							pkt_size = 128;
						else if (long_size_reg > MAX_PACKET_DEF)
							pkt_size = MAX_PACKET_DEF;
						else
							pkt_size = long_size_reg;
						phase = P_BLKNO;
					end else if (c == CH_EOT)
						end_with(CH_ACK, ST_OK);
					else if (c == CH_CAN)
						phase = P_CANWAIT;
					else
						poll();
				end
				P_CANWAIT: begin
					if (is_byte && c == CH_CAN)
						end_with(CH_ACK, ST_CANCEL);
					else
						poll();
				end
				P_BLKNO: begin
					if (!is_byte)
						rx_timeout();
					else begin
						rcv_blk = c;
						phase = P_BLKCMP;
					end
				end
				P_BLKCMP: begin
					if (!is_byte)
						rx_timeout();
					else begin
						byte_cnt = 0;
						crc = 0;
						if (rcv_blk != ~c || (rcv_blk != exp_blk && rcv_blk != exp_blk - 8'd1))
							phase = P_FLUSH;
						else
							phase = P_DATA;
					end
				end
				P_DATA: begin
					if (!is_byte)
						rx_timeout();
					else begin
						crc = crc16_next(crc, c);
						push_res(0, 0, 1, c, byte_cnt[9:0], 0, 0, 0, ST_OK);
						byte_cnt = byte_cnt + 1;
						if (byte_cnt >= pkt_size)
							phase = P_CRCHI;
					end
				end
				P_CRCHI: begin
					if (!is_byte)
						rx_timeout();
					else
						phase = (c == crc[15:8]) ? P_CRCLO : P_CRCLO_BAD;
				end
				P_CRCLO: begin
					if (!is_byte)
						rx_timeout();
					else if (c == crc[7:0]) begin
						push_res(0, 0, 0, 0, 0, 1, pkt_size, 0, ST_OK);
						phase = P_STORE;
					end else
						nak_or_give_up();
				end
				P_CRCLO_BAD: begin
					if (!is_byte)
						rx_timeout();
					else
						nak_or_give_up();
				end
				P_FLUSH: begin
					byte_cnt = byte_cnt + 1;
					if ({1'b0, byte_cnt} >= {1'b0, pkt_size} + 12'd2)
						nak_or_give_up();
				end
				default: ;
			endcase
		end
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i])
			expected_results.push_back(step_res[i]);
	endtask

	task automatic report(input string what, input res_t got, input res_t want);
		fail_count++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_size_reg = 11'd250; retry_limit = 4'd10; phase = P_IDLE; retries = 0;
			exp_blk = 1; rcv_blk = 0; pkt_size = 0; byte_cnt = 0; crc = 0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'(CFG_LONG_SIZE))
					long_size_reg = cfg_data;
				else
					retry_limit = cfg_data[3:0];
			end
			if (out_valid && out_ready) begin
				res_t got;
				res_t want;
				got = res_t'(out_payload);
				if (expected_results.size() == 0)
					report("unexpected result", got, '0);
				else begin
					want = expected_results.pop_front();
					if (got.send_valid !== want.send_valid || got.send_byte !== want.send_byte)
						report("send", got, want);
					else if (got.data_valid !== want.data_valid ||
							got.data_byte !== want.data_byte ||
							got.data_index !== want.data_index)
						report("data", got, want);
					else if (got.packet_ready !== want.packet_ready ||
							got.packet_length !== want.packet_length)
						report("packet", got, want);
					else if (got.done_res !== want.done_res || got.status !== want.status)
						report("status", got, want);
					else if (got.last !== want.last)
						report("last", got, want);
				end
			end
			if (in_valid && in_ready)
				predict_item(in_item_t'(in_payload));
		end
	end

	task automatic report_leftovers();
		if (expected_results.size() != 0) begin
			fail_count++;
			$display("%0d expected results never arrived", expected_results.size());
		end
	endtask
endmodule

>>> tb/sv/tb.sv
module tb;
	import xmcr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 50000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [10:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          src_idle_pct = 0;
	int          snk_stall_pct = 0;
	int          hold_off = 0;

	xmcr_if #(.W(11)) in_ch ();
	xmcr_if #(.W(45)) out_ch ();

	xmodem_crc_receiver_unit u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	xmcr_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_payload(in_ch.payload), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_payload(out_ch.payload), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL xmodem_crc_receiver_unit");
			$finish;
		end
	end

	// receiver side; a long hold-off counts down in here
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// valid stays up between back-to-back transfers; idle gaps drop it
	task automatic send_item(input logic [1:0] act, input logic [7:0] b, input logic sf);
		in_item_t it;
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		it.action = act;
		it.rx_byte = b;
		it.store_failed = sf;
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [10:0] v);
		in_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= 1'(idx);
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] crc_acc(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
		return v;
	endfunction

	// whole packet; flaw: 0 good, 1 bad crc, 2 bad complement, 3 timeout inside
	task automatic send_packet(input logic is_long, input int len,
			input logic [7:0] blk, input int flaw);
		logic [15:0] c;
		c = 16'h0;
		send_item(ACT_BYTE, is_long ? CH_STX : CH_SOH, 1'b0);
		send_item(ACT_BYTE, blk, 1'b0);
		send_item(ACT_BYTE, (flaw == 2) ? blk : ~blk, 1'b0);
		for (int i = 0; i < len; i++) begin
			logic [7:0] d;
			d = 8'($urandom_range(255));
			c = crc_acc(c, d);
			if (flaw == 3 && i == len / 2) begin
				send_item(ACT_TMO, 8'h00, 1'b0);
				return;
			end
			send_item(ACT_BYTE, d, 1'b0);
		end
		send_item(ACT_BYTE, c[15:8], 1'b0);
		send_item(ACT_BYTE, (flaw == 1) ? ~c[7:0] : c[7:0], 1'b0);
	endtask

	// short session of loose events and packets cut off by a timeout
	task automatic random_session(input int n_events);
		send_item(ACT_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
		for (int p = 0; p < n_events; p++) begin
			int r;
			r = $urandom_range(99);
			if (r < 30)
				send_packet(1'($urandom_range(1)), 4, 8'd1, 3);
			else if (r < 55)
				send_item(ACT_TMO, 8'($urandom_range(255)), 1'($urandom_range(1)));
			else if (r < 75)
				send_item(ACT_BYTE, CH_CAN, 1'b0);
			else
				send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
		end
		send_item(ACT_BYTE, CH_EOT, 1'b0);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at reset settings: out-of-place events, polls, cancels
		send_item(ACT_BYTE, 8'hFF, 1'b1);
		send_item(ACT_STORE, 8'h00, 1'b1);
		send_item(ACT_START, 8'h00, 1'b0);
		send_item(ACT_BYTE, 8'h55, 1'b0);
		send_item(ACT_TMO, 8'h00, 1'b0);
		send_item(ACT_BYTE, CH_CAN, 1'b0);
		send_item(ACT_TMO, 8'h00, 1'b0);
		send_item(ACT_BYTE, CH_CAN, 1'b0);
		send_item(ACT_BYTE, CH_CAN, 1'b0);
		send_item(ACT_START, 8'h00, 1'b0);
		send_item(ACT_BYTE, CH_SOH, 1'b0);
		send_item(ACT_TMO, 8'h00, 1'b0);
		send_item(ACT_START, 8'h00, 1'b0);
		send_item(ACT_BYTE, CH_EOT, 1'b0);

		// zero retry limit, then the doubled limit running out before any packet
		write_reg(CFG_RETRIES, 11'd0);
		send_item(ACT_START, 8'h00, 1'b0);
		write_reg(CFG_RETRIES, 11'd2);
		write_reg(CFG_LONG_SIZE, 11'd0);
		send_item(ACT_START, 8'h00, 1'b0);
		repeat (5) send_item(ACT_TMO, 8'h00, 1'b0);

		// sessions across idling phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 68; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 68; end
				default: begin src_idle_pct = 13; snk_stall_pct = 13; end
			endcase
			case (ph)
				0: begin
					hold_off = 300;
					random_session(4);
				end
				1: begin
					// short long-size clamped, store fail on the good packet
					send_item(ACT_START, 8'h00, 1'b0);
					send_packet(1'b1, 128, 8'd1, 0);
					send_item(ACT_STORE, 8'h00, 1'b1);
				end
				2: begin
					// store ok, then a bad crc answered with a NAK
					send_item(ACT_START, 8'h00, 1'b0);
					send_packet(1'b0, 128, 8'd1, 0);
					send_item(ACT_STORE, 8'h00, 1'b0);
					send_packet(1'b0, 128, 8'd2, 1);
				end
				default: begin
					write_reg(CFG_RETRIES, 11'($urandom_range(1, 15)));
					write_reg(CFG_LONG_SIZE, 11'($urandom_range(100, 300)));
					random_session(4);
				end
			endcase
		end

		in_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		u_chk.report_leftovers();
		if (fail_count == 0)
			$display("PASS xmodem_crc_receiver_unit");
		else
			$display("FAIL xmodem_crc_receiver_unit");
		$finish;
	end
endmodule

>>> files.f
sv/xmcr_pkg.sv
sv/xmcr_if.sv
sv/xmcr_engine.sv
sv/xmcr_expander.sv
sv/xmodem_crc_receiver_unit.sv
sv/xmcr_checker.sv
tb/sv/xmcr_checker.sv
tb/sv/tb.sv
